/* hw/rtl/mf3t_pkg.sv */
// ----------------------------------------------------------------------------
// mf3t_pkg: shared types and helpers for the 3x3 median / threshold filter
// pixel and window types, register indexes, sort helpers for the median tree
// ----------------------------------------------------------------------------
`default_nettype none

package mf3t_pkg;

  localparam int PIX_W      = 24;
  localparam int WIN_N      = 9;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  typedef logic [PIX_W-1:0]            pix_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

  localparam pix_t WHITE = 24'hFFFFFF;
  localparam pix_t BLACK = 24'h000000;

  // register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_MODE   = 2'd2,
    CFG_LEVEL  = 2'd3
  } cfg_idx_e;

  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [10:0] HEIGHT_RST = 11'd480;
  localparam logic [7:0]  LEVEL_RST  = 8'd127;

  // per-transaction control from the counter stage to the window stage
  typedef struct packed {
    logic emit_pre;   // column 0: close the previous row's last output
    logic emit_post;  // regular output after the column shift
    logic end_frame;  // drain tick that ends the frame, no line store update
    logic col0;       // first column: window starts white
    logic have_top;   // upper line store holds a real line
    logic have_mid;   // lower line store holds a real line
    logic last;       // emitted pixel is the frame's final one
  } ctl_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] level;
  } thr_t;

  typedef struct packed {
    pix_t lo;
    pix_t mid;
    pix_t hi;
  } trio_t;

  function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
    pix_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
    pix_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    pix_t m;
    if (a > b) begin
      m = (b > c) ? b : ((a > c) ? c : a);
    end else begin
      m = (a > c) ? a : ((b > c) ? c : b);
    end
    return m;
  endfunction

  function automatic trio_t sort3(pix_t a, pix_t b, pix_t c);
    trio_t t;
    t.lo  = min3(a, b, c);
    t.mid = med3(a, b, c);
    t.hi  = max3(a, b, c);
    return t;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/mf3t_ram.sv */
// ----------------------------------------------------------------------------
// mf3t_ram: generic single-port-write, single-port-read RAM
// one write and one registered read per cycle, read data holds when idle
// ----------------------------------------------------------------------------
`default_nettype none

module mf3t_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mf3t_ctrl.sv */
// ----------------------------------------------------------------------------
// mf3t_ctrl: config registers and raster position counters
// decides per transaction what the window stage does and tracks out position
// ----------------------------------------------------------------------------
`default_nettype none

module mf3t_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [mf3t_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [mf3t_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                in_valid_i,
  input  wire logic                                in_ready_i,
  input  wire logic                                in_func_i,
  input  wire mf3t_pkg::pix_t                      in_pixel_i,
  output logic                                     load_o,
  output mf3t_pkg::ctl_t                           ctl_o,
  output logic [$clog2(MAX_WIDTH)-1:0]             col_o,
  output mf3t_pkg::pix_t                           pixel_o,
  output logic                                     restart_o,
  output mf3t_pkg::thr_t                           thr_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 2);
  localparam int EWW = (WW > 11) ? WW : 11;
  localparam int EHW = (HW > 11) ? HW : 11;

  logic [10:0] width_q, height_q;
  logic        mode_q;
  logic [7:0]  level_q;

  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [HW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;

  logic [EWW-1:0] wcfg;
  logic [EHW-1:0] hcfg;
  logic [WW-1:0]  eff_w;
  logic [HW-1:0]  eff_h, eff_h1;

  logic          restart_chk, draining, ignore, accept, size_wr, emit;
  logic [CW-1:0] ic, oc;
  logic [HW-1:0] ir, orow;

  // effective size, clamped into 1 .. max
  always_comb begin
    wcfg = EWW'(width_q);
    hcfg = EHW'(height_q);
    if (wcfg == '0) begin
      eff_w = WW'(1);
    end else if (wcfg > EWW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(wcfg);
    end
    if (hcfg == '0) begin
      eff_h = HW'(1);
    end else if (hcfg > EHW'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(hcfg);
    end
    eff_h1 = eff_h + HW'(1);
  end

  always_comb begin
    restart_chk = (WW'(in_col_q) >= eff_w) || (in_row_q > eff_h1) ||
                  ((in_row_q == eff_h1) && (in_col_q != '0));
    ic   = restart_chk ? '0 : in_col_q;
    ir   = restart_chk ? '0 : in_row_q;
    oc   = restart_chk ? '0 : out_col_q;
    orow = restart_chk ? '0 : out_row_q;

    draining = (ir >= eff_h);
    ignore   = in_func_i && !draining;
    pixel_o  = draining ? mf3t_pkg::WHITE : in_pixel_i;
    col_o    = ic;

    ctl_o.col0      = (ic == '0);
    ctl_o.emit_pre  = ctl_o.col0 && (ir >= HW'(2));
    ctl_o.end_frame = ctl_o.col0 && (ir == eff_h1);
    ctl_o.emit_post = !ctl_o.end_frame && (ic != '0) && (ir != '0);
    ctl_o.have_top  = (ir >= HW'(2));
    ctl_o.have_mid  = (ir != '0);
    ctl_o.last      = (orow == (eff_h - HW'(1))) && (WW'(oc) == (eff_w - WW'(1)));
    emit            = ctl_o.emit_pre || ctl_o.emit_post;

    accept  = in_valid_i && in_ready_i;
    load_o  = accept && !ignore;
    size_wr = cfg_we_i && ((cfg_index_i == mf3t_pkg::CFG_WIDTH) ||
                           (cfg_index_i == mf3t_pkg::CFG_HEIGHT));
    restart_o = size_wr;
  end

  // next raster position
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (size_wr) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (accept) begin
      if (ignore || !ctl_o.end_frame) begin
        in_col_d  = ic;
        in_row_d  = ir;
        out_col_d = oc;
        out_row_d = orow;
      end else begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end
      if (!ignore && !ctl_o.end_frame) begin
        if (emit) begin
          if ((WW'(oc) + WW'(1)) >= eff_w) begin
            out_col_d = '0;
            out_row_d = ((orow + HW'(1)) >= eff_h) ? '0 : orow + HW'(1);
          end else begin
            out_col_d = oc + CW'(1);
          end
        end
        if ((WW'(ic) + WW'(1)) >= eff_w) begin
          in_col_d = '0;
          in_row_d = ir + HW'(1);
        end else begin
          in_col_d = ic + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= mf3t_pkg::WIDTH_RST;
      height_q  <= mf3t_pkg::HEIGHT_RST;
      mode_q    <= 1'b0;
      level_q   <= mf3t_pkg::LEVEL_RST;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          mf3t_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
          mf3t_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
          mf3t_pkg::CFG_MODE:   mode_q   <= cfg_data_i[0];
          mf3t_pkg::CFG_LEVEL:  level_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  assign thr_o.mode  = mode_q;
  assign thr_o.level = level_q;

  // positions stay inside the frame (drain rows included)
  a_in_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(in_col_q) < eff_w) else $error("input column beyond line width");
  a_out_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(out_col_q) < eff_w) else $error("output column beyond line width");
  a_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_row_q <= eff_h1) else $error("input row beyond drain rows");
  a_out_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_row_q < eff_h) else $error("output row beyond frame height");

endmodule

`default_nettype wire

/* hw/rtl/mf3t_window.sv */
// ----------------------------------------------------------------------------
// mf3t_window: line stores and the 3x3 window register
// reads both line stores on acceptance, shifts the window one stage later
// ----------------------------------------------------------------------------
`default_nettype none

module mf3t_window #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        restart_i,
  input  wire logic                        load_i,
  input  wire mf3t_pkg::ctl_t              ctl_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] col_i,
  input  wire mf3t_pkg::pix_t              pixel_i,
  output logic                             ready_o,
  output logic                             emit_valid_o,
  input  wire logic                        emit_ready_i,
  output mf3t_pkg::win_t                   emit_win_o,
  output logic                             emit_last_o
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic           v1_q, fwd1_q;
  mf3t_pkg::ctl_t ctl1_q;
  logic [CW-1:0]  col1_q;
  mf3t_pkg::pix_t pix1_q, fwd_up_q, fwd_lo_q;
  mf3t_pkg::win_t window_q, window_d, pre_win, white_win;

  mf3t_pkg::pix_t up_rd, lo_rd, up_eff, lo_eff, top, mid;
  logic           emit1, adv1, wr1, fwd_d;

  function automatic mf3t_pkg::win_t shift_col(mf3t_pkg::win_t w, mf3t_pkg::pix_t t,
                                               mf3t_pkg::pix_t m, mf3t_pkg::pix_t b);
    mf3t_pkg::win_t r;
    r = w;
    r[0] = w[1]; r[1] = w[2]; r[2] = t;
    r[3] = w[4]; r[4] = w[5]; r[5] = m;
    r[6] = w[7]; r[7] = w[8]; r[8] = b;
    return r;
  endfunction

  mf3t_ram #(.WIDTH(mf3t_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (wr1),
    .waddr_i (col1_q),
    .wdata_i (lo_eff),
    .re_i    (load_i),
    .raddr_i (col_i),
    .rdata_o (up_rd)
  );

  mf3t_ram #(.WIDTH(mf3t_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
    .clk_i   (clk_i),
    .we_i    (wr1),
    .waddr_i (col1_q),
    .wdata_i (pix1_q),
    .re_i    (load_i),
    .raddr_i (col_i),
    .rdata_o (lo_rd)
  );

  always_comb begin
    white_win = {mf3t_pkg::WIN_N{mf3t_pkg::WHITE}};
    emit1     = ctl1_q.emit_pre || ctl1_q.emit_post;
    adv1      = v1_q && (!emit1 || emit_ready_i);
    ready_o   = !v1_q || !emit1 || emit_ready_i;
    wr1       = adv1 && !ctl1_q.end_frame;
    // a write to the same column in the read cycle is bypassed
    fwd_d     = wr1 && (col_i == col1_q);

    up_eff = fwd1_q ? fwd_up_q : up_rd;
    lo_eff = fwd1_q ? fwd_lo_q : lo_rd;
    top    = ctl1_q.have_top ? up_eff : mf3t_pkg::WHITE;
    mid    = ctl1_q.have_mid ? lo_eff : mf3t_pkg::WHITE;

    pre_win = shift_col(window_q, mf3t_pkg::WHITE, mf3t_pkg::WHITE, mf3t_pkg::WHITE);
    if (ctl1_q.end_frame) begin
      window_d = white_win;
    end else if (ctl1_q.col0) begin
      window_d = shift_col(white_win, top, mid, pix1_q);
    end else begin
      window_d = shift_col(window_q, top, mid, pix1_q);
    end

    emit_valid_o = v1_q && emit1;
    emit_win_o   = ctl1_q.emit_pre ? pre_win : window_d;
    emit_last_o  = ctl1_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      fwd1_q   <= 1'b0;
      window_q <= {mf3t_pkg::WIN_N{mf3t_pkg::WHITE}};
    end else begin
      if (load_i) begin
        v1_q   <= 1'b1;
        fwd1_q <= fwd_d;
      end else if (adv1) begin
        v1_q   <= 1'b0;
      end
      if (restart_i) begin
        window_q <= white_win;
      end else if (adv1) begin
        window_q <= window_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ctl1_q   <= ctl_i;
      col1_q   <= col_i;
      pix1_q   <= pixel_i;
      fwd_up_q <= lo_eff;
      fwd_lo_q <= pix1_q;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mf3t_median.sv */
// ----------------------------------------------------------------------------
// mf3t_median: pipelined median of nine and threshold, output register
// rows sorted, then max of lows / median of mids / min of highs, then med3
// ----------------------------------------------------------------------------
`default_nettype none

module mf3t_median (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire mf3t_pkg::win_t in_win_i,
  input  wire logic           in_last_i,
  input  wire mf3t_pkg::thr_t thr_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output mf3t_pkg::pix_t      out_pixel_o,
  output logic                out_last_o
);

  logic va_q, vb_q, vc_q, vo_q;
  logic rdy_a, rdy_b, rdy_c, rdy_o;
  logic last_a_q, last_b_q, last_c_q;

  mf3t_pkg::win_t             win_a_q;
  mf3t_pkg::trio_t [2:0]      rows_d, rows_b_q;
  mf3t_pkg::pix_t             lo_c_q, mid_c_q, hi_c_q, med, res;
  logic [9:0]                 sum, lvl3;

  always_comb begin
    rdy_o = !vo_q || out_ready_i;
    rdy_c = !vc_q || rdy_o;
    rdy_b = !vb_q || rdy_c;
    rdy_a = !va_q || rdy_b;
    in_ready_o = rdy_a;

    for (int r = 0; r < 3; r++) begin
      rows_d[r] = mf3t_pkg::sort3(win_a_q[3*r], win_a_q[3*r+1], win_a_q[3*r+2]);
    end

    med  = mf3t_pkg::med3(lo_c_q, mid_c_q, hi_c_q);
    sum  = 10'(med[23:16]) + 10'(med[15:8]) + 10'(med[7:0]);
    // floor(sum / 3) < level exactly when sum < 3 * level
    lvl3 = 10'({thr_i.level, 1'b0}) + 10'(thr_i.level);
    if (thr_i.mode) begin
      res = (sum < lvl3) ? mf3t_pkg::BLACK : mf3t_pkg::WHITE;
    end else begin
      res = med;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_o) vo_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      win_a_q  <= in_win_i;
      last_a_q <= in_last_i;
    end
    if (rdy_b && va_q) begin
      rows_b_q <= rows_d;
      last_b_q <= last_a_q;
    end
    if (rdy_c && vb_q) begin
      lo_c_q   <= mf3t_pkg::max3(rows_b_q[0].lo, rows_b_q[1].lo, rows_b_q[2].lo);
      mid_c_q  <= mf3t_pkg::med3(rows_b_q[0].mid, rows_b_q[1].mid, rows_b_q[2].mid);
      hi_c_q   <= mf3t_pkg::min3(rows_b_q[0].hi, rows_b_q[1].hi, rows_b_q[2].hi);
      last_c_q <= last_b_q;
    end
    if (rdy_o && vc_q) begin
      out_pixel_o <= res;
      out_last_o  <= last_c_q;
    end
  end

  assign out_valid_o = vo_q;

endmodule

`default_nettype wire

/* hw/rtl/median_filter_3x3_threshold_top.sv */
// ----------------------------------------------------------------------------
// median_filter_3x3_threshold_top: streaming 3x3 median filter for RGB pixels
// line-store based median of nine with white border and optional binarizing
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata = pixel_value, tuser = func
//  m_axis    out  tvalid/tready          tdata = out_pixel, tlast = last_of_frame
//  cfg       in   cfg_we_i (no wait)     cfg_index_i, cfg_data_i
//
//  one transaction per clock in and out while m_axis does not stall;
//  m_axis_tvalid for a pixel rises once the transaction completing its
//  neighborhood has passed line store read, window shift, row sort, median,
//  threshold/output register; the throughput figure is set by the single-port
//  read of each line store per transaction, which the next pixel never waits on
//  a flush tick before the frame ends completes but yields no result
//  back-pressure on m_axis fills the four result stages and the window stage
//  before s_axis stalls
//  reset clears counters, window (to white) and the config to its defaults;
//  line stores need no clearing, each entry is written before its data is used
//
`default_nettype none

module median_filter_3x3_threshold_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input pixel stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [23:0]                     s_axis_tdata,  // [23:0] pixel_value
  input  wire logic                            s_axis_tuser,  // [0] func
  // filtered pixel stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [23:0]                          m_axis_tdata,  // [23:0] out_pixel
  output logic                                 m_axis_tlast,
  // configuration writes
  input  wire logic                            cfg_we_i,
  input  wire logic [mf3t_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mf3t_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic           load, restart, win_ready;
  mf3t_pkg::ctl_t ctl;
  logic [CW-1:0]  col;
  mf3t_pkg::pix_t pixel;
  mf3t_pkg::thr_t thr;

  logic           emit_valid, emit_ready, emit_last;
  mf3t_pkg::win_t emit_win;

  // raster counters and config registers
  mf3t_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (win_ready),
    .in_func_i   (s_axis_tuser),
    .in_pixel_i  (s_axis_tdata),
    .load_o      (load),
    .ctl_o       (ctl),
    .col_o       (col),
    .pixel_o     (pixel),
    .restart_o   (restart),
    .thr_o       (thr)
  );

  // line stores plus the 3x3 window
  mf3t_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (restart),
    .load_i       (load),
    .ctl_i        (ctl),
    .col_i        (col),
    .pixel_i      (pixel),
    .ready_o      (win_ready),
    .emit_valid_o (emit_valid),
    .emit_ready_i (emit_ready),
    .emit_win_o   (emit_win),
    .emit_last_o  (emit_last)
  );

  // median tree, threshold and output register
  mf3t_median u_median (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (emit_valid),
    .in_ready_o  (emit_ready),
    .in_win_i    (emit_win),
    .in_last_i   (emit_last),
    .thr_i       (thr),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pixel_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  assign s_axis_tready = win_ready;

endmodule

`default_nettype wire

/* verif/tb_median_filter_3x3_threshold_top.sv */
// ----------------------------------------------------------------------------
// tb_median_filter_3x3_threshold_top: self-checking bench for the 3x3 median
// streams framed pixel runs with random gaps and sink stalls, predicts every
// filtered pixel and frame-end flag in a local model and compares in order
// ----------------------------------------------------------------------------

module tb_median_filter_3x3_threshold_top;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;

  // input item kinds carried on tuser
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // hard stop, far beyond the slowest legal run
  localparam longint unsigned RUN_LIMIT = 64'd20_000_000;

  // cycles to let the pipeline go quiet before a register write
  localparam int QUIET_CYCLES = 16;

  typedef struct packed {
    logic           func;
    mf3t_pkg::pix_t pixel;
  } src_item_t;

  typedef struct packed {
    mf3t_pkg::pix_t pixel;
    logic           last;
  } result_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // pixel stream into the filter
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;    // [23:0] pixel_value
  logic        s_axis_tuser  = 1'b0;  // [0] func

  // filtered stream out of the filter
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;          // [23:0] out_pixel
  logic        m_axis_tlast;

  // register write port
  logic                            cfg_we_i    = 1'b0;
  logic [mf3t_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [mf3t_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  median_filter_3x3_threshold_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // filter model: register copies, line buffers, window and raster counters
  // --------------------------------------------------------------------------
  logic [10:0] reg_width;
  logic [10:0] reg_height;
  logic        reg_mode;
  logic [7:0]  reg_level;

  mf3t_pkg::pix_t upper_line [MAX_W];
  mf3t_pkg::pix_t lower_line [MAX_W];
  mf3t_pkg::pix_t win [9];     // row-major, index 3*row + col

  int unsigned col_in, row_in, col_out, row_out;

  // queues between stimulus, driver, model and checker
  src_item_t pixel_items[$];
  result_t   expected_pixels[$];

  int unsigned fail_count = 0;

  // sizes outside 1..max behave as the nearest bound
  function automatic int unsigned active_width();
    if (reg_width == 0) return 1;
    if (reg_width > MAX_W) return MAX_W;
    return 32'(reg_width);
  endfunction

  function automatic int unsigned active_height();
    if (reg_height == 0) return 1;
    if (reg_height > MAX_H) return MAX_H;
    return 32'(reg_height);
  endfunction

  function automatic void blank_window();
    for (int k = 0; k < 9; k++) win[k] = mf3t_pkg::WHITE;
  endfunction

  function automatic void clear_frame();
    col_in  = 0;
    row_in  = 0;
    col_out = 0;
    row_out = 0;
    blank_window();
  endfunction

  // move the window one column left, new column enters on the right
  function automatic void slide_window(mf3t_pkg::pix_t top, mf3t_pkg::pix_t mid,
                                       mf3t_pkg::pix_t bot);
    for (int r = 0; r < 3; r++) begin
      win[3*r]     = win[3*r + 1];
      win[3*r + 1] = win[3*r + 2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = bot;
  endfunction

  // fifth smallest of the nine packed words, compared as plain integers
  function automatic mf3t_pkg::pix_t median_of_nine();
    mf3t_pkg::pix_t v [9];
    mf3t_pkg::pix_t key;
    int             b;
    for (int k = 0; k < 9; k++) v[k] = win[k];
    for (int a = 1; a < 9; a++) begin
      key = v[a];
      b = a;
      while (b > 0 && v[b-1] > key) begin
        v[b] = v[b-1];
        b--;
      end
      v[b] = key;
    end
    return v[4];
  endfunction

  function automatic void push_result(int unsigned w, int unsigned h);
    result_t        res;
    mf3t_pkg::pix_t m;
    int unsigned    avg;
    m = median_of_nine();
    if (reg_mode) begin
      avg = (int'(m[23:16]) + int'(m[15:8]) + int'(m[7:0])) / 3;
      m = (avg < reg_level) ? mf3t_pkg::BLACK : mf3t_pkg::WHITE;
    end
    res.pixel = m;
    res.last  = (row_out == h - 1 && col_out == w - 1);
    expected_pixels.push_back(res);
    col_out++;
    if (col_out >= w) begin
      col_out = 0;
      row_out++;
      if (row_out >= h) row_out = 0;
    end
  endfunction

  // one accepted input transaction: advance raster, queue what it yields
  function automatic void filter_step(logic func, mf3t_pkg::pix_t pix);
    int unsigned    w, h, c, r;
    mf3t_pkg::pix_t top, mid, p;
    logic           draining;
    w = active_width();
    h = active_height();
    p = pix;
    if (col_in >= w || row_in > h + 1 || (row_in == h + 1 && col_in != 0)) clear_frame();
    draining = (row_in >= h);
    // a flush inside the frame does nothing
    if (func == FUNC_FLUSH && !draining) return;
    // past the last line every item is white bottom padding
    if (draining) p = mf3t_pkg::WHITE;
    c = col_in;
    r = row_in;
    if (c == 0) begin
      // close the previous line with a white right border
      if (r >= 2) begin
        slide_window(mf3t_pkg::WHITE, mf3t_pkg::WHITE, mf3t_pkg::WHITE);
        push_result(w, h);
      end
      if (r == h + 1) begin
        clear_frame();
        return;
      end
      blank_window();
    end
    top = (r >= 2) ? upper_line[c] : mf3t_pkg::WHITE;
    mid = (r >= 1) ? lower_line[c] : mf3t_pkg::WHITE;
    upper_line[c] = lower_line[c];
    lower_line[c] = p;
    slide_window(top, mid, p);
    if (c >= 1 && r >= 1) push_result(w, h);
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // gap length: mostly none, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  mf3t_pkg::pix_t last_drawn = mf3t_pkg::BLACK;

  function automatic mf3t_pkg::pix_t random_pixel();
    int unsigned    r;
    int             c;
    mf3t_pkg::pix_t p;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      p = 24'($urandom);
    end else if (r < 60) begin
      case ($urandom_range(0, 3))
        0:       p = mf3t_pkg::BLACK;
        1:       p = mf3t_pkg::WHITE;
        2:       p = 24'h7FFFFF;
        default: p = 24'h800000;
      endcase
    end else if (r < 80) begin
      // gray near the threshold so the average lands on both sides of it
      c = int'(reg_level) + int'($urandom_range(0, 6)) - 3;
      if (c < 0) c = 0;
      if (c > 255) c = 255;
      p = {c[7:0], c[7:0], c[7:0]};
      if ($urandom_range(0, 1)) p[15:8] = (c == 255) ? 8'd254 : c[7:0] + 8'd1;
    end else begin
      // repeat for ties in the sort
      p = last_drawn;
    end
    last_drawn = p;
    return p;
  endfunction

  task automatic queue_item(input logic func, input mf3t_pkg::pix_t pix);
    src_item_t it;
    it.func  = func;
    it.pixel = pix;
    pixel_items.push_back(it);
  endtask

  // raster of w x h pixels then w+1 drain items, cut after 'limit' items
  task automatic queue_frame(input int unsigned w, input int unsigned h,
                             input int unsigned limit);
    for (int unsigned n = 0; n < limit; n++) begin
      if (n < w * h) begin
        // stray flush inside the frame, ignored by the block
        if ($urandom_range(0, 19) == 0) queue_item(FUNC_FLUSH, random_pixel());
        queue_item(FUNC_PIXEL, random_pixel());
      end else if ($urandom_range(0, 1)) begin
        queue_item(FUNC_FLUSH, random_pixel());
      end else begin
        queue_item(FUNC_PIXEL, random_pixel());
      end
    end
  endtask

  // register write on the config port, mirrored into the model
  task automatic write_reg(input mf3t_pkg::cfg_idx_e idx, input logic [10:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      mf3t_pkg::CFG_WIDTH: begin
        reg_width = val;
        clear_frame();
      end
      mf3t_pkg::CFG_HEIGHT: begin
        reg_height = val;
        clear_frame();
      end
      mf3t_pkg::CFG_MODE:  reg_mode  = val[0];
      mf3t_pkg::CFG_LEVEL: reg_level = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // all items sent, all results back, then let flush-only work retire
  task automatic settle();
    while (pixel_items.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // driver: presents queued items on the input side, changes at falling edge
  // --------------------------------------------------------------------------
  logic        in_taken = 1'b0;   // input transaction at the last rising edge
  int unsigned send_gap  = 0;
  int unsigned send_calm = 0;
  src_item_t   next_item;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (send_gap != 0) begin
        send_gap = send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_items.size() != 0) begin
        next_item = pixel_items.pop_front();
        s_axis_tdata  <= next_item.pixel;
        s_axis_tuser  <= next_item.func;
        s_axis_tvalid <= 1'b1;
        // now and then a long run with no gaps
        if (send_calm != 0) begin
          send_calm = send_calm - 1;
        end else begin
          send_gap = idle_len();
          if ($urandom_range(0, 63) == 0) send_calm = $urandom_range(20, 80);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sink: random back-pressure on the output side
  // --------------------------------------------------------------------------
  int unsigned hold_cnt  = 0;
  int unsigned hold_calm = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt = hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (hold_calm != 0) begin
        hold_calm = hold_calm - 1;
      end else begin
        hold_cnt = idle_len();
        if ($urandom_range(0, 63) == 0) hold_calm = $urandom_range(20, 80);
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: model update on each input transaction, in-order output check
  // --------------------------------------------------------------------------
  result_t want;

  always @(posedge clk_i) begin
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) filter_step(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected output transaction: pixel %06h last %0b",
                     m_axis_tdata, m_axis_tlast);
        end else begin
          want = expected_pixels.pop_front();
          if (m_axis_tdata !== want.pixel || m_axis_tlast !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: pixel exp %06h got %06h, last exp %0b got %0b",
                       want.pixel, m_axis_tdata, want.last, m_axis_tlast);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned fw, fh, w, h, k, phase, random_items, limit;
    logic        broken;

    // register defaults, counters cleared, window white
    reg_width  = mf3t_pkg::WIDTH_RST;
    reg_height = mf3t_pkg::HEIGHT_RST;
    reg_mode   = 1'b0;
    reg_level  = mf3t_pkg::LEVEL_RST;
    clear_frame();

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // small 3x2 frame, median mode: extreme words, a stray flush inside
    // the frame, drain by both flush ticks and pixels past the end
    write_reg(mf3t_pkg::CFG_WIDTH, 11'd3);
    write_reg(mf3t_pkg::CFG_HEIGHT, 11'd2);
    write_reg(mf3t_pkg::CFG_MODE, 11'd0);
    queue_item(FUNC_PIXEL, mf3t_pkg::BLACK);
    queue_item(FUNC_PIXEL, mf3t_pkg::WHITE);
    queue_item(FUNC_PIXEL, 24'h800000);
    queue_item(FUNC_FLUSH, 24'h5A5A5A);
    queue_item(FUNC_PIXEL, 24'h000001);
    queue_item(FUNC_PIXEL, 24'h7FFFFF);
    queue_item(FUNC_PIXEL, 24'hFFFFFE);
    queue_item(FUNC_PIXEL, 24'h123456);
    queue_item(FUNC_FLUSH, mf3t_pkg::BLACK);
    queue_item(FUNC_FLUSH, mf3t_pkg::WHITE);
    queue_item(FUNC_PIXEL, 24'hABCDEF);
    settle();

    // zero sizes act as 1x1; threshold level zero never gives black
    write_reg(mf3t_pkg::CFG_WIDTH, 11'd0);
    write_reg(mf3t_pkg::CFG_HEIGHT, 11'd0);
    write_reg(mf3t_pkg::CFG_MODE, 11'd1);
    write_reg(mf3t_pkg::CFG_LEVEL, 11'd0);
    queue_item(FUNC_PIXEL, mf3t_pkg::BLACK);
    queue_item(FUNC_FLUSH, mf3t_pkg::BLACK);
    queue_item(FUNC_FLUSH, mf3t_pkg::WHITE);
    settle();

    // top threshold level: only full white stays white
    write_reg(mf3t_pkg::CFG_WIDTH, 11'd2);
    write_reg(mf3t_pkg::CFG_HEIGHT, 11'd2);
    write_reg(mf3t_pkg::CFG_LEVEL, 11'd255);
    queue_item(FUNC_PIXEL, mf3t_pkg::WHITE);
    queue_item(FUNC_PIXEL, 24'hFFFFFE);
    queue_item(FUNC_PIXEL, mf3t_pkg::BLACK);
    queue_item(FUNC_PIXEL, mf3t_pkg::WHITE);
    queue_item(FUNC_PIXEL, mf3t_pkg::BLACK);
    queue_item(FUNC_PIXEL, mf3t_pkg::BLACK);
    queue_item(FUNC_PIXEL, mf3t_pkg::BLACK);
    settle();

    // frame cut short, then a size write restarts it
    write_reg(mf3t_pkg::CFG_WIDTH, 11'd4);
    write_reg(mf3t_pkg::CFG_HEIGHT, 11'd3);
    write_reg(mf3t_pkg::CFG_MODE, 11'd0);
    for (k = 0; k < 6; k++) queue_item(FUNC_PIXEL, random_pixel());
    settle();
    write_reg(mf3t_pkg::CFG_WIDTH, 11'd4);

    // random phases: mostly whole frames, some cut short, a few huge sizes
    broken       = 1'b1;
    phase        = 0;
    random_items = 0;
    while (random_items < 800 || phase < 9) begin
      settle();
      if (phase == 2) begin
        fw = 2047;   // clamps to the widest line
        fh = 2;
      end else if (phase == 5) begin
        fw = 1;
        fh = 2047;   // clamps to the tallest frame
      end else if (phase == 8) begin
        fw = 1024;
        fh = 1;
      end else begin
        k  = $urandom_range(0, 99);
        fw = (k < 5) ? 0 : (k < 75) ? $urandom_range(1, 8) : $urandom_range(9, 24);
        k  = $urandom_range(0, 99);
        fh = (k < 5) ? 0 : (k < 85) ? $urandom_range(1, 6) : $urandom_range(7, 12);
      end
      if (broken || phase == 2 || phase == 5 || phase == 8 || $urandom_range(0, 9) < 7) begin
        write_reg(mf3t_pkg::CFG_WIDTH, fw[10:0]);
        write_reg(mf3t_pkg::CFG_HEIGHT, fh[10:0]);
      end
      if ($urandom_range(0, 1)) begin
        write_reg(mf3t_pkg::CFG_MODE, {10'd0, 1'($urandom_range(0, 1))});
        k = $urandom_range(0, 99);
        write_reg(mf3t_pkg::CFG_LEVEL, (k < 15) ? 11'd0 : (k < 30) ? 11'd255
                                      : 11'($urandom_range(0, 255)));
      end
      w = active_width();
      h = active_height();
      broken = 1'b0;
      if (phase == 2 || phase == 5 || phase == 8) begin
        // clamped or maximal sizes: only the start of the frame, a size write follows
        limit = $urandom_range(20, 60);
        queue_frame(w, h, limit);
        random_items += limit;
        broken = 1'b1;
      end else if ($urandom_range(0, 99) < 85) begin
        // back-to-back frames, each starts right after the previous drain
        k = (w * h + w + 1 > 60) ? 1 : $urandom_range(1, 3);
        repeat (k) begin
          queue_frame(w, h, w * h + w + 1);
          random_items += w * h + w + 1;
        end
      end else begin
        limit = $urandom_range(1, w * h + w);
        queue_frame(w, h, limit);
        random_items += limit;
        broken = 1'b1;
      end
      phase++;
    end

    settle();
    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mf3t_pkg.sv
hw/rtl/mf3t_ram.sv
hw/rtl/mf3t_ctrl.sv
hw/rtl/mf3t_window.sv
hw/rtl/mf3t_median.sv
hw/rtl/median_filter_3x3_threshold_top.sv
verif/tb_median_filter_3x3_threshold_top.sv
